// ===== hw/rtl/ps2ied_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2ied_pkg
// types, codes and keymap tables shared by the ps/2 event decoder
// ----------------------------------------------------------------------------
package ps2ied_pkg;

    // field widths
    localparam int CURSOR_W      = 12;
    localparam int MAXC_W        = 12;
    localparam int CFG_DATA_W    = 12;
    localparam int CFG_INDEX_W   = 2;
    localparam int COORD_BITS_DFLT = 12;

    // reset values
    localparam int POS_X_RST = 400;
    localparam int POS_Y_RST = 300;
    localparam logic [MAXC_W-1:0] MAX_X_RST = 12'd799;
    localparam logic [MAXC_W-1:0] MAX_Y_RST = 12'd599;

    // result queue
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // mouse packet status bits
    localparam int PKT_SYNC_BIT = 3;

    // set-1 scancodes with special handling
    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_CTRL   = 7'h1D;
    localparam logic [6:0] SC_ALT    = 7'h38;
    localparam logic [6:0] SC_CAPS   = 7'h3A;
    localparam logic [6:0] SC_SPACE  = 7'h39;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    typedef enum logic [1:0] {
        EV_NONE       = 2'd0,
        EV_KEY_DOWN   = 2'd1,
        EV_MOUSE_DOWN = 2'd2,
        EV_MOUSE_UP   = 2'd3
    } event_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MOUSE_EN = 2'd0,
        CFG_KBD_EN   = 2'd1,
        CFG_MAX_X    = 2'd2,
        CFG_MAX_Y    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic       from_aux;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]          event_kind;
        logic [31:0]         event_message;
        logic [CURSOR_W-1:0] cursor_x;
        logic [CURSOR_W-1:0] cursor_y;
        logic [2:0]          mouse_buttons;
        logic [3:0]          modifier_bits;
        logic                last_result;
    } out_beat_t;

    // mouse unit to top
    typedef struct packed {
        logic fire;
        logic press;
    } mouse_evt_t;

    // keyboard unit to top
    typedef struct packed {
        logic        fire;
        logic        space;
        logic [31:0] message;
    } kbd_evt_t;

    localparam int TABLE_LEN = 84;

    localparam logic [7:0] LOW_TAB [TABLE_LEN] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E
    };

    localparam logic [7:0] UP_TAB [TABLE_LEN] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
        8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
        8'h32, 8'h33, 8'h30, 8'h2E
    };

    // us keymap lookup; caps lock only flips letters
    function automatic logic [7:0] kbd_translate(input logic [6:0] code,
                                                 input logic shift,
                                                 input logic caps);
        logic [7:0] base;
        logic [7:0] ch;
        base = 8'h00;
        ch   = 8'h00;
        if (code < 7'(TABLE_LEN))
        begin
            base = LOW_TAB[code];
            if (base inside {[8'h61:8'h7A]})
            begin
                ch = (shift != caps) ? (base - 8'h20) : base;
            end
            else
            begin
                ch = shift ? UP_TAB[code] : base;
            end
        end
        return ch;
    endfunction

endpackage

// ===== hw/rtl/ps2ied_mouse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2ied_mouse
// 3-byte packet assembly, clamped cursor and left-button events
// ----------------------------------------------------------------------------
module ps2ied_mouse #(
    parameter int COORD_BITS = ps2ied_pkg::COORD_BITS_DFLT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take,
    input  logic [7:0]                      data_byte,
    input  logic [ps2ied_pkg::MAXC_W-1:0]   max_x,
    input  logic [ps2ied_pkg::MAXC_W-1:0]   max_y,
    output logic [COORD_BITS-1:0]           pos_x_next,
    output logic [COORD_BITS-1:0]           pos_y_next,
    output logic [2:0]                      buttons_next,
    output ps2ied_pkg::mouse_evt_t          evt
);
    import ps2ied_pkg::*;

    // wide enough for coordinate plus signed delta and the 12-bit bound
    localparam int CW = ((COORD_BITS > MAXC_W) ? COORD_BITS : MAXC_W) + 2;

    logic [COORD_BITS-1:0] pos_x_reg, pos_y_reg;
    logic [2:0]            buttons_reg;
    logic [1:0]            cnt_reg, cnt_next;
    logic [7:0]            pkt0_reg, pkt1_reg;

    logic [CW-1:0]         cmax;
    logic [CW-1:0]         bnd_x, bnd_y;
    logic signed [CW-1:0]  sum_x, sum_y;
    logic                  pkt_done;

    function automatic logic [COORD_BITS-1:0] clamp(input logic signed [CW-1:0] v,
                                                    input logic [CW-1:0] bnd);
        logic [CW-1:0] r;
        if (v[CW-1])
        begin
            r = '0;
        end
        else if ($unsigned(v) > bnd)
        begin
            r = bnd;
        end
        else
        begin
            r = $unsigned(v);
        end
        return r[COORD_BITS-1:0];
    endfunction

    assign cmax  = {{(CW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
    assign bnd_x = ({{(CW-MAXC_W){1'b0}}, max_x} > cmax) ? cmax
                                                         : {{(CW-MAXC_W){1'b0}}, max_x};
    assign bnd_y = ({{(CW-MAXC_W){1'b0}}, max_y} > cmax) ? cmax
                                                         : {{(CW-MAXC_W){1'b0}}, max_y};

    // x adds the delta, y subtracts it
    assign sum_x = $signed({{(CW-COORD_BITS){1'b0}}, pos_x_reg})
                 + $signed({{(CW-8){pkt1_reg[7]}}, pkt1_reg});
    assign sum_y = $signed({{(CW-COORD_BITS){1'b0}}, pos_y_reg})
                 - $signed({{(CW-8){data_byte[7]}}, data_byte});

    // third byte of a packet without overflow bits
    assign pkt_done = take && (cnt_reg == 2'd2) && (pkt0_reg[7:6] == 2'b00);

    always_comb
    begin
        cnt_next     = cnt_reg;
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        buttons_next = buttons_reg;
        evt          = '0;
        if (take)
        begin
            case (cnt_reg)
                2'd0:    cnt_next = data_byte[PKT_SYNC_BIT] ? 2'd1 : 2'd0;
                2'd1:    cnt_next = 2'd2;
                default: cnt_next = 2'd0;
            endcase
        end
        if (pkt_done)
        begin
            pos_x_next   = clamp(sum_x, bnd_x);
            pos_y_next   = clamp(sum_y, bnd_y);
            buttons_next = pkt0_reg[2:0];
            evt.fire     = pkt0_reg[0] ^ buttons_reg[0];
            evt.press    = pkt0_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= COORD_BITS'(POS_X_RST);
            pos_y_reg   <= COORD_BITS'(POS_Y_RST);
            buttons_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            buttons_reg <= buttons_next;
            cnt_reg     <= cnt_next;
        end
    end

    // packet bytes, no reset
    always_ff @(posedge clk)
    begin
        if (take && (cnt_reg == 2'd0) && data_byte[PKT_SYNC_BIT])
        begin
            pkt0_reg <= data_byte;
        end
        if (take && (cnt_reg == 2'd1))
        begin
            pkt1_reg <= data_byte;
        end
    end

endmodule

// ===== hw/rtl/ps2ied_kbd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2ied_kbd
// set-1 scancode modifiers, caps lock and key-down translation
// ----------------------------------------------------------------------------
module ps2ied_kbd (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic [7:0]             data_byte,
    output logic [3:0]             mods_next,
    output ps2ied_pkg::kbd_evt_t   evt
);
    import ps2ied_pkg::*;

    logic       shift_reg, ctrl_reg, alt_reg, caps_reg;
    logic       shift_next, ctrl_next, alt_next, caps_next;
    logic       rel;
    logic [6:0] code;
    logic [7:0] ch;

    assign rel  = data_byte[7];
    assign code = data_byte[6:0];
    assign ch   = kbd_translate(code, shift_reg, caps_reg);

    always_comb
    begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        alt_next   = alt_reg;
        caps_next  = caps_reg;
        evt        = '0;
        if (take)
        begin
            case (code) inside
                SC_LSHIFT, SC_RSHIFT: shift_next = !rel;
                SC_CTRL:              ctrl_next  = !rel;
                SC_ALT:               alt_next   = !rel;
                SC_CAPS:              caps_next  = rel ? caps_reg : !caps_reg;
                default:
                begin
                    if (!rel && (ch != 8'h00))
                    begin
                        evt.fire    = 1'b1;
                        evt.space   = (code == SC_SPACE) && (ch == ASCII_SPACE);
                        // ctrl 0x1000, alt 0x0800, caps 0x0400, shift 0x0200 above bit 16
                        evt.message = {3'b000, ctrl_reg, alt_reg, caps_reg, shift_reg,
                                       9'd0, 1'b0, code, ch};
                    end
                end
            endcase
        end
    end

    assign mods_next = {caps_next, alt_next, ctrl_next, shift_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
            alt_reg   <= 1'b0;
            caps_reg  <= 1'b0;
        end
        else
        begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            alt_reg   <= alt_next;
            caps_reg  <= caps_next;
        end
    end

endmodule

// ===== hw/rtl/ps2ied_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2ied_outq
// small result queue, takes one or two beats, hands out one a cycle unless out_stall is high
// ----------------------------------------------------------------------------
module ps2ied_outq (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push0,
    input  logic                    push1,
    input  ps2ied_pkg::out_beat_t   beat0,
    input  ps2ied_pkg::out_beat_t   beat1,
    output logic                    room,
    output logic                    out_valid,
    input  logic                    out_stall,
    output ps2ied_pkg::out_beat_t   out_beat
);
    import ps2ied_pkg::*;

    out_beat_t             mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  pop;
    logic [OUTQ_CNT_W-1:0] n_push;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (cnt_reg != '0);
    assign out_beat  = mem[rd_ptr_reg];
    // space for a two-beat item
    assign room      = (cnt_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));

    assign n_push      = OUTQ_CNT_W'(push0) + OUTQ_CNT_W'(push1);
    assign wr_ptr_next = wr_ptr_reg + OUTQ_PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + OUTQ_PTR_W'(pop);
    assign cnt_next    = cnt_reg + n_push - OUTQ_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem[wr_ptr_reg] <= beat0;
        end
        if (push1)
        begin
            mem[wr_ptr_reg + OUTQ_PTR_W'(1)] <= beat1;
        end
    end

endmodule

// ===== hw/rtl/ps2_input_event_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_input_event_decoder_unit
// decodes tagged ps/2 bytes into key and mouse events with cursor status
// ----------------------------------------------------------------------------
//  channel   beat          handshake            direction
//  in        in_beat_t     in_valid/in_stall    bytes from keyboard or aux port
//  out       out_beat_t    out_valid/out_stall  one or two result beats per byte
//  cfg       cfg_data      cfg_wr_en/cfg_index  register writes, no read-back
//
//  one byte accepted per cycle while in_stall is low; a byte passes through
//  the input register into the result queue, which offers its result beats;
//  a space press gives two beats, so the out side sets the sustained rate
//  when spaces are frequent; the four-entry result queue sets the slack
//  reset: cursor 400,300, buttons, packet count and modifiers cleared
//  in_stall rises only while the input register holds a byte and the
//  queue has no room for two beats
// ----------------------------------------------------------------------------
module ps2_input_event_decoder_unit #(
    parameter int COORD_BITS = ps2ied_pkg::COORD_BITS_DFLT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  ps2ied_pkg::in_beat_t                 in_beat,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output ps2ied_pkg::out_beat_t                out_beat,
    input  logic                                 cfg_wr_en,
    input  logic [ps2ied_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ps2ied_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ps2ied_pkg::*;

    // configuration registers
    logic              mouse_en_reg, kbd_en_reg;
    logic [MAXC_W-1:0] max_x_reg, max_y_reg;

    // input register stage
    logic     in_valid_reg, in_valid_next;
    in_beat_t in_beat_reg;
    logic     adv;
    logic     room;

    // unit hand-offs
    logic                  mouse_take, kbd_take;
    logic [COORD_BITS-1:0] pos_x_next, pos_y_next;
    logic [2:0]            buttons_next;
    logic [3:0]            mods_next;
    mouse_evt_t            m_evt;
    kbd_evt_t              k_evt;

    // result beats
    out_beat_t           beat0, beat1;
    out_beat_t           status;
    logic                two;
    logic [CURSOR_W-1:0] cx, cy;
    logic [31:0]         pos_msg;

    // config writes are to arrive only while idle; the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mouse_en_reg <= 1'b0;
            kbd_en_reg   <= 1'b0;
            max_x_reg    <= MAX_X_RST;
            max_y_reg    <= MAX_Y_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_MOUSE_EN: mouse_en_reg <= cfg_data[0];
                CFG_KBD_EN:   kbd_en_reg   <= cfg_data[0];
                CFG_MAX_X:    max_x_reg    <= cfg_data[MAXC_W-1:0];
                CFG_MAX_Y:    max_y_reg    <= cfg_data[MAXC_W-1:0];
                default:      ;
            endcase
        end
    end

    // byte leaves the input register once the queue can take two beats
    assign adv           = in_valid_reg && room;
    assign in_stall      = in_valid_reg && !room;
    assign in_valid_next = in_stall ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_beat_reg <= in_beat;
        end
    end

    // disabled ports drop their bytes but still yield a status beat
    assign mouse_take = adv && in_beat_reg.from_aux && mouse_en_reg;
    assign kbd_take   = adv && !in_beat_reg.from_aux && kbd_en_reg;

    ps2ied_mouse #(
        .COORD_BITS (COORD_BITS)
    ) u_mouse (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (mouse_take),
        .data_byte    (in_beat_reg.data_byte),
        .max_x        (max_x_reg),
        .max_y        (max_y_reg),
        .pos_x_next   (pos_x_next),
        .pos_y_next   (pos_y_next),
        .buttons_next (buttons_next),
        .evt          (m_evt)
    );

    ps2ied_kbd u_kbd (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (kbd_take),
        .data_byte (in_beat_reg.data_byte),
        .mods_next (mods_next),
        .evt       (k_evt)
    );

    // every beat reports the state left by this byte
    assign cx      = CURSOR_W'(pos_x_next);
    assign cy      = CURSOR_W'(pos_y_next);
    assign pos_msg = {{(16-CURSOR_W){1'b0}}, cx, {(16-CURSOR_W){1'b0}}, cy};

    always_comb
    begin
        status               = '0;
        status.cursor_x      = cx;
        status.cursor_y      = cy;
        status.mouse_buttons = buttons_next;
        status.modifier_bits = mods_next;

        beat0 = status;
        beat1 = status;
        two   = 1'b0;

        if (m_evt.fire)
        begin
            beat0.event_kind    = m_evt.press ? EV_MOUSE_DOWN : EV_MOUSE_UP;
            beat0.event_message = pos_msg;
        end
        else if (k_evt.fire)
        begin
            beat0.event_kind    = EV_KEY_DOWN;
            beat0.event_message = k_evt.message;
            // space also acts as a mouse press
            if (k_evt.space)
            begin
                two                 = 1'b1;
                beat1.event_kind    = EV_MOUSE_DOWN;
                beat1.event_message = pos_msg;
            end
        end

        beat0.last_result = !two;
        beat1.last_result = 1'b1;
    end

    ps2ied_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (adv),
        .push1     (adv && two),
        .beat0     (beat0),
        .beat1     (beat1),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

endmodule
